FILE: rtl/es2c_pkg.sv
// Package for the epoch-seconds calendar decoder.
// Holds the sequencer states, calendar constants, the month table and the
// shared unit's result type. No dependencies.
package es2c_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY_Q,
        ST_DAY_R,
        ST_HOUR_Q,
        ST_HOUR_R,
        ST_MIN_Q,
        ST_MIN_R,
        ST_YEAR,
        ST_WDAY_Q,
        ST_WDAY_R,
        ST_MON,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        ge;
        logic [31:0] diff;
    } t_alu_res;

    // Reciprocals for exact division by the odd part of each divisor. The
    // dividend is first shifted right by the divisor's power of two, and the
    // quotient is the product shifted right by the exponent noted beside it.
    localparam logic [25:0] DAY_RECIP  = 26'd50903317; // 2^35 / 675, rounded up
    localparam logic [25:0] HOUR_RECIP = 26'd9321;     // 2^21 / 225, rounded up
    localparam logic [25:0] MIN_RECIP  = 26'd1093;     // 2^14 / 15, rounded up
    localparam logic [25:0] WDAY_RECIP = 26'd586;      // 2^12 / 7, rounded up

    localparam logic [25:0] SECS_PER_DAY  = 26'd86400;
    localparam logic [25:0] SECS_PER_HOUR = 26'd3600;
    localparam logic [25:0] SECS_PER_MIN  = 26'd60;
    localparam logic [25:0] DAYS_PER_WEEK = 26'd7;

    localparam logic [11:0] EPOCH_YEAR = 12'd1970;
    localparam logic [1:0]  EPOCH_Y4   = 2'd2;
    localparam logic [6:0]  EPOCH_Y100 = 7'd70;
    localparam logic [8:0]  EPOCH_Y400 = 9'd370;
    // The first day of the epoch was a Thursday.
    localparam logic [2:0]  EPOCH_WDAY = 3'd4;

    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [8:0] DAYS_LEAP   = 9'd366;

    localparam logic [8:0] CUM_DAYS [0:1][0:12] = '{
        '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
          9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365},
        '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
          9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366}
    };

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
        logic [8:0] d;
        d = CUM_DAYS[leap][mon] - CUM_DAYS[leap][mon - 4'd1];
        return d[4:0];
    endfunction

endpackage

FILE: rtl/es2c_alu.sv
// Shared subtract-and-compare unit of the calendar decoder.
// Depends on es2c_pkg for the result type.
module es2c_alu (
    input  logic [31:0]        i_a,
    input  logic [31:0]        i_b,
    output es2c_pkg::t_alu_res o_res
);
    import es2c_pkg::*;

    logic [32:0] d;

    assign d          = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~d[32];
    assign o_res.diff = d[31:0];

endmodule

FILE: rtl/epoch_seconds_to_calendar.sv
// Epoch seconds to Gregorian calendar decoder.
// Input channel: i_valid / o_stall with i_epoch_seconds; a transfer happens on an
// edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with the calendar fields held in an output
// register; a transfer happens on an edge where o_valid is high and i_stall is low.
// One subtract-and-compare unit and one shared multiplier do all the work under a
// sequencer. Days, hours, minutes and the weekday each take a quotient state and
// a remainder state: a reciprocal multiply gives the quotient, then a subtract
// gives the remainder. The years from 1970 are walked one at a time in ST_YEAR
// and the months one at a time in ST_MON, and these walks set the latency. The
// input stalls from an input transfer until the result moves into the output
// register, so one item is in work at a time.
// A finished result moves into the output register once that register is
// free, and the input opens again in the next cycle, even while the receiver
// stalls the previous result. A stalled result holds its value.
// Reset (i_rst_n low, synchronous) returns to idle and drops o_valid.
// Depends on es2c_pkg and es2c_alu.
module epoch_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second_of_minute,
    output logic [2:0]  o_weekday
);
    import es2c_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_acc, n_acc;
    logic [15:0] r_quo, n_quo;
    logic [15:0] r_days, n_days;
    logic [11:0] r_yr, n_yr;
    logic [1:0]  r_y4, n_y4;
    logic [6:0]  r_y100, n_y100;
    logic [8:0]  r_y400, n_y400;
    logic [2:0]  r_wd, n_wd;
    logic [8:0]  r_doy, n_doy;
    logic [3:0]  r_mo, n_mo;
    logic [4:0]  r_dm, n_dm;
    logic [4:0]  r_hr, n_hr;
    logic [5:0]  r_mn, n_mn;
    logic [5:0]  r_sc, n_sc;

    logic        r_out_valid, n_out_valid;
    logic [11:0] r_o_year, n_o_year;
    logic [3:0]  r_o_month, n_o_month;
    logic [4:0]  r_o_dom, n_o_dom;
    logic [4:0]  r_o_hour, n_o_hour;
    logic [5:0]  r_o_min, n_o_min;
    logic [5:0]  r_o_sec, n_o_sec;
    logic [2:0]  r_o_wday, n_o_wday;

    t_alu_res    alu_res;
    logic [31:0] operand;
    logic        leap;
    logic [8:0]  ylen;
    logic [3:0]  wd_sum;
    logic [25:0] mul_a;
    logic [25:0] mul_b;
    logic [51:0] product;

    es2c_alu u_alu (
        .i_a   (r_acc),
        .i_b   (operand),
        .o_res (alu_res)
    );

    assign leap     = ((r_y4 == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);
    assign ylen     = leap ? DAYS_LEAP : DAYS_COMMON;
    // Weekday advances one day per common year and two per leap year.
    assign wd_sum   = {1'b0, r_wd} + 4'd1 + {3'b000, leap};
    assign product  = mul_a * mul_b;

    // Quotient states multiply the pre-shifted dividend by a reciprocal;
    // remainder states multiply the quotient back by the divisor.
    always_comb begin
        case (r_state)
            ST_DAY_Q: begin
                mul_a = {1'b0, r_acc[31:7]};
                mul_b = DAY_RECIP;
            end
            ST_HOUR_Q: begin
                mul_a = {13'd0, r_acc[16:4]};
                mul_b = HOUR_RECIP;
            end
            ST_MIN_Q: begin
                mul_a = {16'd0, r_acc[11:2]};
                mul_b = MIN_RECIP;
            end
            ST_WDAY_Q: begin
                mul_a = {17'd0, r_acc[8:0]};
                mul_b = WDAY_RECIP;
            end
            ST_DAY_R: begin
                mul_a = {10'd0, r_quo};
                mul_b = SECS_PER_DAY;
            end
            ST_HOUR_R: begin
                mul_a = {10'd0, r_quo};
                mul_b = SECS_PER_HOUR;
            end
            ST_MIN_R: begin
                mul_a = {10'd0, r_quo};
                mul_b = SECS_PER_MIN;
            end
            ST_WDAY_R: begin
                mul_a = {10'd0, r_quo};
                mul_b = DAYS_PER_WEEK;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            ST_YEAR: operand = {23'd0, ylen};
            ST_MON:  operand = {27'd0, month_len(leap, r_mo)};
            default: operand = product[31:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_quo     <= n_quo;
        r_days    <= n_days;
        r_yr      <= n_yr;
        r_y4      <= n_y4;
        r_y100    <= n_y100;
        r_y400    <= n_y400;
        r_wd      <= n_wd;
        r_doy     <= n_doy;
        r_mo      <= n_mo;
        r_dm      <= n_dm;
        r_hr      <= n_hr;
        r_mn      <= n_mn;
        r_sc      <= n_sc;
        r_o_year  <= n_o_year;
        r_o_month <= n_o_month;
        r_o_dom   <= n_o_dom;
        r_o_hour  <= n_o_hour;
        r_o_min   <= n_o_min;
        r_o_sec   <= n_o_sec;
        r_o_wday  <= n_o_wday;
    end

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_quo       = r_quo;
        n_days      = r_days;
        n_yr        = r_yr;
        n_y4        = r_y4;
        n_y100      = r_y100;
        n_y400      = r_y400;
        n_wd        = r_wd;
        n_doy       = r_doy;
        n_mo        = r_mo;
        n_dm        = r_dm;
        n_hr        = r_hr;
        n_mn        = r_mn;
        n_sc        = r_sc;
        n_out_valid = r_out_valid;
        n_o_year    = r_o_year;
        n_o_month   = r_o_month;
        n_o_dom     = r_o_dom;
        n_o_hour    = r_o_hour;
        n_o_min     = r_o_min;
        n_o_sec     = r_o_sec;
        n_o_wday    = r_o_wday;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_acc   = i_epoch_seconds;
                    n_state = ST_DAY_Q;
                end
            end
            ST_DAY_Q: begin
                n_quo   = product[50:35];
                n_days  = product[50:35];
                n_state = ST_DAY_R;
            end
            ST_DAY_R: begin
                n_acc   = alu_res.diff;
                n_state = ST_HOUR_Q;
            end
            ST_HOUR_Q: begin
                n_quo   = {11'd0, product[25:21]};
                n_hr    = product[25:21];
                n_state = ST_HOUR_R;
            end
            ST_HOUR_R: begin
                n_acc   = alu_res.diff;
                n_state = ST_MIN_Q;
            end
            ST_MIN_Q: begin
                n_quo   = {10'd0, product[19:14]};
                n_mn    = product[19:14];
                n_state = ST_MIN_R;
            end
            ST_MIN_R: begin
                n_sc    = alu_res.diff[5:0];
                n_acc   = {16'd0, r_days};
                n_yr    = EPOCH_YEAR;
                n_y4    = EPOCH_Y4;
                n_y100  = EPOCH_Y100;
                n_y400  = EPOCH_Y400;
                n_wd    = EPOCH_WDAY;
                n_state = ST_YEAR;
            end
            ST_YEAR: begin
                if (alu_res.ge) begin
                    n_acc  = alu_res.diff;
                    n_yr   = r_yr + 12'd1;
                    n_y4   = r_y4 + 2'd1;
                    n_y100 = (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
                    n_y400 = (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                    n_wd   = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
                end else begin
                    // Remaining days are the day of the year; the weekday is
                    // the year's first weekday plus that, reduced by 7.
                    n_doy   = r_acc[8:0];
                    n_acc   = {23'd0, r_acc[8:0]} + {29'd0, r_wd};
                    n_state = ST_WDAY_Q;
                end
            end
            ST_WDAY_Q: begin
                n_quo   = {10'd0, product[17:12]};
                n_state = ST_WDAY_R;
            end
            ST_WDAY_R: begin
                n_wd    = alu_res.diff[2:0];
                n_acc   = {23'd0, r_doy};
                n_mo    = 4'd1;
                n_state = ST_MON;
            end
            ST_MON: begin
                if (alu_res.ge) begin
                    n_acc = alu_res.diff;
                    n_mo  = r_mo + 4'd1;
                end else begin
                    n_dm    = r_acc[4:0] + 5'd1;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_o_year    = r_yr;
                    n_o_month   = r_mo;
                    n_o_dom     = r_dm;
                    n_o_hour    = r_hr;
                    n_o_min     = r_mn;
                    n_o_sec     = r_sc;
                    n_o_wday    = r_wd;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall            = (r_state != ST_IDLE);
    assign o_valid            = r_out_valid;
    assign o_year             = r_o_year;
    assign o_month            = r_o_month;
    assign o_day_of_month     = r_o_dom;
    assign o_hour             = r_o_hour;
    assign o_minute           = r_o_min;
    assign o_second_of_minute = r_o_sec;
    assign o_weekday          = r_o_wday;

endmodule

FILE: rtl/es2c_checker.sv
// Port-level checks for the calendar decoder, with the bind that attaches
// them to epoch_seconds_to_calendar. Depends on the top level's ports only.
module es2c_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [31:0] i_epoch_seconds,
    input logic        o_valid,
    input logic        i_stall,
    input logic [11:0] o_year,
    input logic [3:0]  o_month,
    input logic [4:0]  o_day_of_month,
    input logic [4:0]  o_hour,
    input logic [5:0]  o_minute,
    input logic [5:0]  o_second_of_minute,
    input logic [2:0]  o_weekday
);

    // A stalled result keeps its value until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_year) && $stable(o_month)
            && $stable(o_day_of_month) && $stable(o_hour) && $stable(o_minute)
            && $stable(o_second_of_minute) && $stable(o_weekday)))
        else $error("stalled result changed");

    // An input transfer closes the input for the conversion that follows.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input open right after a transfer");

    // A conversion runs through its quotient and remainder states first, so no result follows at once.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !o_valid) |=> !o_valid)
        else $error("result appeared one cycle after an input transfer");

    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month >= 4'd1 && o_month <= 4'd12
            && o_day_of_month >= 5'd1 && o_hour <= 5'd23
            && o_minute <= 6'd59 && o_second_of_minute <= 6'd59
            && o_weekday <= 3'd6 && o_year >= 12'd1970 && o_year <= 12'd2106))
        else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar es2c_checker u_es2c_checker (.*);
